### sv/mfr_pkg.sv
// Shared types, constants and helpers for the multitap feedback reverb.
// Used by mfr_ctrl, mfr_dp and the top level; depends on nothing.
package mfr_pkg;

    localparam int unsigned MFR_STORE_DEPTH = 65536;

    localparam int unsigned DRY_W   = 20;
    localparam int unsigned WET_W   = 16;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned MUL_B_W = 18;
    localparam int unsigned PROD_W  = DRY_W + MUL_B_W;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned QUOT_W  = PROD_W - FRAC_W + 1;
    localparam int unsigned AGE_W   = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // Q0.16 coefficients, rounded to nearest
    localparam logic [COEF_W-1:0] COEF_TENTH        = 16'd6554;
    localparam logic [COEF_W-1:0] COEF_FIFTH        = 16'd13107;
    localparam logic [COEF_W-1:0] COEF_THREE_TENTHS = 16'd19661;
    localparam logic [COEF_W-1:0] COEF_TWO_FIFTHS   = 16'd26214;

    localparam int unsigned TAP_COUNT = 7;
    localparam int unsigned TAP_W     = $clog2(TAP_COUNT);

    localparam logic [AGE_W-1:0] TAP_AGE [TAP_COUNT] = '{
        16'd7000, 16'd10008, 16'd13996, 16'd17098, 16'd21088, 16'd29172, 16'd37956
    };

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DRY,
        MUL_TAP,
        MUL_Y3,
        MUL_Y2,
        MUL_Y1,
        MUL_R
    } t_mul_sel;

    typedef enum logic [1:0] {
        NORM_NONE,
        NORM_DRY,
        NORM_TAP
    } t_norm_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic             capture;
        logic             rd_en;
        logic [TAP_W-1:0] rd_tap;
        t_mul_sel         mul;
        t_norm_sel        norm;
        t_acc_op          acc;
        logic             commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    // Divide by 2^16 truncating toward zero, then saturate to 16 bits
    function automatic logic [WET_W-1:0] norm16(input logic [PROD_W-1:0] v);
        logic              rnd;
        logic [QUOT_W-1:0] q;
        logic [WET_W-1:0]  res;
        rnd = v[PROD_W-1] && (v[FRAC_W-1:0] != '0);
        q   = {v[PROD_W-1], v[PROD_W-1:FRAC_W]} + QUOT_W'(rnd);
        if ((q[QUOT_W-1:WET_W-1] == '0) || (q[QUOT_W-1:WET_W-1] == '1)) begin
            res = q[WET_W-1:0];
        end else if (q[QUOT_W-1]) begin
            res = {1'b1, {(WET_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WET_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

### sv/mfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mfr_ctrl.sv
// Sequencer for the reverb datapath: steps one sample through the schedule.
// Depends on mfr_pkg.
module mfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_dry_valid,
    output logic          o_dry_stall,
    input  mfr_pkg::t_stat i_stat,
    output mfr_pkg::t_cmd  o_cmd
);
    import mfr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    localparam int unsigned STEP_LAST_I = 12;
    localparam int unsigned STEP_W      = $clog2(STEP_LAST_I + 1);

    // schedule, as step indices within the run state
    localparam logic [STEP_W-1:0] ST_DRY_MUL      = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_DRY_NORM     = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_TAP_RD_LAST  = STEP_W'(TAP_COUNT - 1);
    localparam logic [STEP_W-1:0] ST_TAP_MUL_LAST = STEP_W'(TAP_COUNT);
    localparam logic [STEP_W-1:0] ST_TAP_NORM_LO  = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_TAP_NORM_HI  = STEP_W'(TAP_COUNT + 1);
    localparam logic [STEP_W-1:0] ST_Y3_MUL       = STEP_W'(TAP_COUNT + 1);
    localparam logic [STEP_W-1:0] ST_Y2_MUL       = STEP_W'(TAP_COUNT + 2);
    localparam logic [STEP_W-1:0] ST_Y1_MUL       = STEP_W'(TAP_COUNT + 3);
    localparam logic [STEP_W-1:0] ST_R_MUL        = STEP_W'(TAP_COUNT + 4);
    localparam logic [STEP_W-1:0] ST_ACC_LOAD     = STEP_W'(TAP_COUNT + 2);
    localparam logic [STEP_W-1:0] ST_LAST         = STEP_W'(STEP_LAST_I);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_stall, n_stall;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_dry_valid;
        o_cmd.commit  = (r_state == S_DONE) && !i_stat.out_busy;
        o_cmd.rd_en   = 1'b0;
        o_cmd.rd_tap  = r_step[TAP_W-1:0];
        o_cmd.mul     = MUL_NONE;
        o_cmd.norm    = NORM_NONE;
        o_cmd.acc     = ACC_HOLD;
        if (r_state == S_RUN) begin
            o_cmd.rd_en = (r_step <= ST_TAP_RD_LAST);
            if (r_step == ST_DRY_MUL) begin
                o_cmd.mul = MUL_DRY;
            end else if (r_step <= ST_TAP_MUL_LAST) begin
                o_cmd.mul = MUL_TAP;
            end else begin
                case (r_step)
                    ST_Y3_MUL: o_cmd.mul = MUL_Y3;
                    ST_Y2_MUL: o_cmd.mul = MUL_Y2;
                    ST_Y1_MUL: o_cmd.mul = MUL_Y1;
                    ST_R_MUL:  o_cmd.mul = MUL_R;
                    default:   o_cmd.mul = MUL_NONE;
                endcase
            end
            if (r_step == ST_DRY_NORM) begin
                o_cmd.norm = NORM_DRY;
            end else if ((r_step >= ST_TAP_NORM_LO) && (r_step <= ST_TAP_NORM_HI)) begin
                o_cmd.norm = NORM_TAP;
            end
            if (r_step == ST_ACC_LOAD) begin
                o_cmd.acc = ACC_LOAD;
            end else if (r_step > ST_ACC_LOAD) begin
                o_cmd.acc = ACC_ADD;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_dry_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_step == ST_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_stall <= n_stall;
        end
    end

    assign o_dry_stall = r_stall;

endmodule

### sv/mfr_dp.sv
// Reverb datapath: shared multiplier, accumulator, history, pointers, output register.
// Depends on mfr_pkg; drives the delay RAM ports.
module mfr_dp #(
    parameter int unsigned STORE_DEPTH = mfr_pkg::MFR_STORE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mfr_pkg::t_cmd                  i_cmd,
    output mfr_pkg::t_stat                 o_stat,
    input  logic [mfr_pkg::DRY_W-1:0]      i_dry_sample,
    input  logic [mfr_pkg::GAIN_W-1:0]     i_gain,
    output logic                           o_wet_valid,
    input  logic                           i_wet_stall,
    output logic [mfr_pkg::WET_W-1:0]      o_wet_sample,
    output logic                           o_ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_waddr,
    output logic [mfr_pkg::WET_W-1:0]      o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_raddr,
    input  logic [mfr_pkg::WET_W-1:0]      i_ram_rdata
);
    import mfr_pkg::*;

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned FW = $clog2(STORE_DEPTH + 1);

    logic [DRY_W-1:0]  r_dry;
    logic [WET_W-1:0]  r_r, r_y1, r_y2, r_y3;
    logic [PROD_W-1:0] r_prod, r_acc;
    logic              r_tap_ok;
    logic [AW-1:0]     r_wp;
    logic [FW-1:0]     r_fill;
    logic              r_out_valid;
    logic [WET_W-1:0]  r_out_data;

    logic [AW-1:0]            tap_age;
    logic [AW:0]              diff;
    logic [AW:0]              wrapped;
    logic                     tap_hit;
    logic signed [DRY_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] product;
    logic [PROD_W-1:0]        norm_in;
    logic [WET_W-1:0]         y_new;

    // tap address = write pointer minus age, modulo the store depth
    assign tap_age = AW'(TAP_AGE[i_cmd.rd_tap]);
    assign diff    = {1'b0, r_wp} - {1'b0, tap_age};
    assign wrapped = diff + (AW+1)'(STORE_DEPTH);
    // a tap's entry counts as written only once the fill count has reached its age
    assign tap_hit = (r_fill >= FW'(tap_age));

    assign o_ram_re    = i_cmd.rd_en;
    assign o_ram_raddr = diff[AW] ? wrapped[AW-1:0] : diff[AW-1:0];

    always_comb begin
        case (i_cmd.mul)
            MUL_DRY: begin
                mul_a = r_dry;
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, i_gain};
            end
            MUL_TAP: begin
                mul_a = r_tap_ok ? {{(DRY_W-WET_W){i_ram_rdata[WET_W-1]}}, i_ram_rdata} : '0;
                mul_b = {{(MUL_B_W-COEF_W){1'b0}}, COEF_TENTH};
            end
            MUL_Y3: begin
                mul_a = {{(DRY_W-WET_W){r_y3[WET_W-1]}}, r_y3};
                mul_b = {{(MUL_B_W-COEF_W){1'b0}}, COEF_TENTH};
            end
            MUL_Y2: begin
                mul_a = {{(DRY_W-WET_W){r_y2[WET_W-1]}}, r_y2};
                mul_b = {{(MUL_B_W-COEF_W){1'b0}}, COEF_FIFTH};
            end
            MUL_Y1: begin
                mul_a = {{(DRY_W-WET_W){r_y1[WET_W-1]}}, r_y1};
                mul_b = {{(MUL_B_W-COEF_W){1'b0}}, COEF_THREE_TENTHS};
            end
            MUL_R: begin
                mul_a = {{(DRY_W-WET_W){r_r[WET_W-1]}}, r_r};
                mul_b = {{(MUL_B_W-COEF_W){1'b0}}, COEF_TWO_FIFTHS};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    always_comb begin
        case (i_cmd.norm)
            NORM_TAP: norm_in = {{(PROD_W-WET_W-FRAC_W){r_r[WET_W-1]}}, r_r, {FRAC_W{1'b0}}}
                                + r_prod;
            default:  norm_in = r_prod;
        endcase
    end

    assign y_new = norm16(r_acc);

    always_ff @(posedge i_clk) begin
        r_prod <= product;
        if (i_cmd.capture) begin
            r_dry <= i_dry_sample;
        end
        if (i_cmd.rd_en) begin
            r_tap_ok <= tap_hit;
        end
        if (i_cmd.norm != NORM_NONE) begin
            r_r <= norm16(norm_in);
        end
        case (i_cmd.acc)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.commit) begin
            r_out_data <= y_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
            r_y3        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_wet_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                r_y1        <= y_new;
                r_y2        <= r_y1;
                r_y3        <= r_y2;
                r_wp        <= (r_wp == AW'(STORE_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                if (r_fill != FW'(STORE_DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    assign o_ram_we    = i_cmd.commit;
    assign o_ram_waddr = r_wp;
    assign o_ram_wdata = y_new;

    assign o_stat.out_busy = r_out_valid && i_wet_stall;
    assign o_wet_valid     = r_out_valid;
    assign o_wet_sample    = r_out_data;

endmodule

### sv/multitap_feedback_reverb.sv
// Top level of the multitap feedback reverb: APB gain register, sequencer,
// datapath and delay memory. Depends on mfr_pkg, mfr_ram, mfr_ctrl and mfr_dp.
//
// Each input beat is one summed dry sample; each output beat is one wet sample.
// The dry sample is scaled by volume_gain (Q0.16), then seven feedback taps of
// 0.1 times earlier outputs are added one after another, each add truncated and
// saturated to 16 bits, and the result is smoothed with the last three outputs
// as 0.4*r + 0.3*y1 + 0.2*y2 + 0.1*y3 before going into the circular delay
// memory (STORE_DEPTH x 16 bits). One multiply-accumulate unit is shared by
// every product and the seven taps come one per cycle from the memory's single
// read port, each feeding the next. A stalled output holds back the commit while
// the output register is still full; the next beat can be taken as soon as the
// current result has been placed in the output register, while it waits there,
// so a new beat is taken only after the current sample has been committed.
// There is no clearing pass after reset: a fill count marks which entries are
// written, and unwritten taps read as zero. volume_gain sits at byte addresses 0
// to 3 and resets to one quarter; addresses 4 to 7 read as zero and ignore writes.
module multitap_feedback_reverb #(
    parameter int unsigned STORE_DEPTH = mfr_pkg::MFR_STORE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // dry sample channel
    input  logic                         i_dry_valid,
    output logic                         o_dry_stall,
    input  logic [mfr_pkg::DRY_W-1:0]    i_dry_sample,
    // wet sample channel
    output logic                         o_wet_valid,
    input  logic                         i_wet_stall,
    output logic [mfr_pkg::WET_W-1:0]    o_wet_sample,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mfr_pkg::*;

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam logic        REG_VOLUME_GAIN = 1'b0;  // register index from paddr[2]

    t_cmd              cmd;
    t_stat             stat;
    logic [GAIN_W-1:0] r_gain;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WET_W-1:0]  ram_wdata, ram_rdata;

    // configuration: written on the access phase, no wait states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_VOLUME_GAIN)) begin
            r_gain <= pwdata[GAIN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VOLUME_GAIN) ? {{(32-GAIN_W){1'b0}}, r_gain} : '0;

    mfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dry_valid (i_dry_valid),
        .o_dry_stall (o_dry_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mfr_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_dry_sample (i_dry_sample),
        .i_gain       (r_gain),
        .o_wet_valid  (o_wet_valid),
        .i_wet_stall  (i_wet_stall),
        .o_wet_sample (o_wet_sample),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    // delay memory: one write per sample, seven tap reads per sample
    mfr_ram #(
        .WIDTH (WET_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a taken beat keeps the block busy for at least the next cycle
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dry_valid && !o_dry_stall) |=> o_dry_stall)
        else $error("input taken but block not busy next cycle");

    // a result only shows up out of a commit step
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_wet_valid) |-> $past(cmd.commit))
        else $error("output valid rose without a commit");

    // a commit always lands in the output register
    a_commit_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_wet_valid)
        else $error("commit did not produce an output beat");

    // never capture a new sample while the previous one is still being worked
    a_no_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> (!o_dry_stall && !cmd.commit && (cmd.mul == MUL_NONE)))
        else $error("capture overlapped with a running sample");

endmodule
